// File: rtl/core/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg
// Shared constants, command types and helper functions for the SYN cookie
// challenge builder.
// ----------------------------------------------------------------------------
package scc_pkg;

   // Field widths of the channels
   localparam int WORD_W   = 16;
   localparam int COOKIE_W = 32;
   localparam int CSUM_W   = 16;
   localparam int SECRET_W = 32;

   // Running sums: at most 30 summed words of 16 bits
   localparam int SUM_W  = 21;
   // Final TCP sum adds addresses, pseudo-header and cookie words
   localparam int TSUM_W = 22;

   // Header word position, saturates at POS_MAX
   localparam int POS_W = 6;
   localparam logic [POS_W-1:0] POS_MAX = 6'd63;

   // FNV-1a style hash constants
   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;

   localparam logic [7:0] NEW_TTL   = 8'd64;
   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] FLAGS_SYN_ACK = 8'h12;
   localparam logic [3:0] MIN_HDR_LEN   = 4'd5;

   // Hash step operand select
   localparam logic [1:0] MUL_SEL_SA    = 2'd0;
   localparam logic [1:0] MUL_SEL_DA    = 2'd1;
   localparam logic [1:0] MUL_SEL_PORTS = 2'd2;

   // Commands from controller to datapath
   typedef struct packed {
      logic       accept;   // header word taken this cycle
      logic       mul_en;   // run one hash multiply step
      logic [1:0] mul_sel;  // which key goes into the step
      logic       finish;   // load result word and clear packet state
   } scc_cmd_type;

   function automatic logic [31:0] swap32(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

   function automatic logic [15:0] swap16(input logic [15:0] v);
      return {v[7:0], v[15:8]};
   endfunction

   // Ones-complement fold of a TSUM_W bit sum, then invert
   function automatic logic [15:0] fold_invert(input logic [TSUM_W-1:0] s);
      logic [16:0] a;
      logic [15:0] b;
      a = {1'b0, s[15:0]} + 17'(s[TSUM_W-1:16]);
      b = a[15:0] + {15'b0, a[16]};
      return ~b;
   endfunction

endpackage

// File: rtl/core/scc_req_if.sv
// ----------------------------------------------------------------------------
// scc_req_if
// Header word channel: valid/ready handshake carrying one 16-bit word.
// ----------------------------------------------------------------------------
interface scc_req_if;
   logic                         valid;
   logic                         ready;
   logic [scc_pkg::WORD_W-1:0]   header_word;
   logic                         last;

   modport source (output valid, output header_word, output last, input ready);
   modport sink   (input valid, input header_word, input last, output ready);
endinterface

// File: rtl/core/scc_rsp_if.sv
// ----------------------------------------------------------------------------
// scc_rsp_if
// Result channel: valid/ready handshake carrying cookie, checksums and flags.
// ----------------------------------------------------------------------------
interface scc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [scc_pkg::COOKIE_W-1:0]  cookie;
   logic [scc_pkg::CSUM_W-1:0]    ip_checksum;
   logic [scc_pkg::CSUM_W-1:0]    tcp_checksum;
   logic                          seq_matches;
   logic                          header_error;

   modport source (output valid, output cookie, output ip_checksum,
                   output tcp_checksum, output seq_matches, output header_error,
                   input ready);
   modport sink   (input valid, input cookie, input ip_checksum,
                   input tcp_checksum, input seq_matches, input header_error,
                   output ready);
endinterface

// File: rtl/core/syn_cookie_challenge_builder_unit.sv
// ----------------------------------------------------------------------------
// syn_cookie_challenge_builder_unit
// SYN cookie and SYN-ACK challenge checksum builder for IPv4/TCP headers.
// ----------------------------------------------------------------------------
// Usage:
//  - req_if carries the IPv4 header then the TCP header as 16-bit words in
//    network order, one word per cycle; last marks the final TCP word.
//  - rsp_if gives one result word per packet: cookie, new IP checksum, new
//    TCP checksum, sequence-match flag and header-error flag.
//  - csr_write_enable/csr_write_data load the cookie secret; write it only
//    while no packet is in flight.
//  - Sequence: after the last word of a packet is taken, the hash runs its
//    SA, DA and ports steps (one 32x32 low multiply each), then a final
//    state mixes, sums and loads the output register. The next packet can
//    start in the cycle after the load.
//  - The output register lets the next packet stream in while a result
//    waits; if rsp stalls, the following packet holds in the load cycle
//    until the pending word is taken.
//  - Reset clears the secret, packet state and the output valid.
// ----------------------------------------------------------------------------
module syn_cookie_challenge_builder_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [scc_pkg::SECRET_W-1:0]  csr_write_data,
   scc_req_if.sink                       req_if,
   scc_rsp_if.source                     rsp_if
);

   scc_pkg::scc_cmd_type cmd;

   // Sequencer
   scc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_last  (req_if.last),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd)
   );

   // Parser, checksums and hash
   scc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .header_word      (req_if.header_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cookie           (rsp_if.cookie),
      .ip_checksum      (rsp_if.ip_checksum),
      .tcp_checksum     (rsp_if.tcp_checksum),
      .seq_matches      (rsp_if.seq_matches),
      .header_error     (rsp_if.header_error)
   );

endmodule

// File: rtl/core/scc_datapath.sv
// ----------------------------------------------------------------------------
// scc_datapath
// Header parser, running checksums, cookie hash steps and result register.
// ----------------------------------------------------------------------------
module scc_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  scc_pkg::scc_cmd_type           cmd,
   input  logic [scc_pkg::WORD_W-1:0]     header_word,
   input  logic                           csr_write_enable,
   input  logic [scc_pkg::SECRET_W-1:0]   csr_write_data,
   output logic [scc_pkg::COOKIE_W-1:0]   cookie,
   output logic [scc_pkg::CSUM_W-1:0]     ip_checksum,
   output logic [scc_pkg::CSUM_W-1:0]     tcp_checksum,
   output logic                           seq_matches,
   output logic                           header_error
);

   localparam int PW = scc_pkg::POS_W;
   localparam int SW = scc_pkg::SUM_W;
   localparam int TW = scc_pkg::TSUM_W;

   logic [31:0]    secret_ff;
   logic [PW-1:0]  pos_ff,     pos_in;
   logic [3:0]     ip_len_ff,  ip_len_in;
   logic [3:0]     tcp_len_ff, tcp_len_in;
   logic [SW-1:0]  ip_sum_ff,  ip_sum_in;
   logic [SW-1:0]  tcp_sum_ff, tcp_sum_in;
   logic [31:0]    sa_ff, sa_in;
   logic [31:0]    da_ff, da_in;
   logic [15:0]    sp_ff, sp_in;
   logic [15:0]    dp_ff, dp_in;
   logic [31:0]    seq_ff, seq_in;
   logic [31:0]    hash_ff, hash_in;

   logic [31:0]    cookie_ff;
   logic [15:0]    ip_csum_ff, tcp_csum_ff;
   logic           match_ff, err_ff;

   // Per-word parse signals
   logic [3:0]     ihl_eff;
   logic [4:0]     ip_words;
   logic           in_ip;
   logic [PW-1:0]  tpos;
   logic           tcp_take;
   logic [15:0]    ip_val, tcp_val;

   // Finish signals
   logic [31:0]    mul_src, mul_key, mul_op;
   logic [31:0]    h_final;
   logic [TW-1:0]  ck_sum;
   logic [TW-1:0]  tsum;
   logic [6:0]     len_total;
   logic           err_now;

   // Header word parse: lengths, field capture and rewritten word values
   always_comb begin
      ip_len_in  = ip_len_ff;
      tcp_len_in = tcp_len_ff;
      sa_in      = sa_ff;
      da_in      = da_ff;
      sp_in      = sp_ff;
      dp_in      = dp_ff;
      seq_in     = seq_ff;
      ip_sum_in  = ip_sum_ff;
      tcp_sum_in = tcp_sum_ff;
      pos_in     = pos_ff;

      if (pos_ff == '0) begin
         ip_len_in = header_word[11:8];
      end
      ihl_eff  = (ip_len_in < scc_pkg::MIN_HDR_LEN) ? scc_pkg::MIN_HDR_LEN : ip_len_in;
      ip_words = {ihl_eff, 1'b0};
      in_ip    = pos_ff < PW'(ip_words);
      tpos     = pos_ff - PW'(ip_words);

      if (!in_ip && tpos == PW'(6)) begin
         tcp_len_in = header_word[15:12];
      end
      tcp_take = !in_ip && (tpos < PW'(6) || tpos < PW'({tcp_len_in, 1'b0}));

      // IP word as it reads in the challenge
      case (pos_ff)
         PW'(4):  ip_val = {scc_pkg::NEW_TTL, header_word[7:0]};
         PW'(5):  ip_val = '0;
         default: ip_val = header_word;
      endcase

      // TCP word as it reads in the challenge (seq/ack added at the end)
      case (tpos)
         PW'(0), PW'(1):                 tcp_val = header_word;
         PW'(2), PW'(3), PW'(4), PW'(5): tcp_val = '0;
         PW'(6):  tcp_val = {header_word[15:8], scc_pkg::FLAGS_SYN_ACK};
         PW'(7), PW'(8), PW'(9):         tcp_val = '0;
         default: tcp_val = header_word;
      endcase

      if (cmd.accept) begin
         if (in_ip) begin
            ip_sum_in = ip_sum_ff + SW'(ip_val);
            case (pos_ff)
               PW'(6):  sa_in = {header_word, sa_ff[15:0]};
               PW'(7):  sa_in = {sa_ff[31:16], header_word};
               PW'(8):  da_in = {header_word, da_ff[15:0]};
               PW'(9):  da_in = {da_ff[31:16], header_word};
               default: ;
            endcase
         end else if (tcp_take) begin
            tcp_sum_in = tcp_sum_ff + SW'(tcp_val);
            case (tpos)
               PW'(0):  sp_in  = header_word;
               PW'(1):  dp_in  = header_word;
               PW'(2):  seq_in = {header_word, seq_ff[15:0]};
               PW'(3):  seq_in = {seq_ff[31:16], header_word};
               default: ;
            endcase
         end
         if (pos_ff < scc_pkg::POS_MAX) begin
            pos_in = pos_ff + PW'(1);
         end
      end else begin
         // length fields only latch with an accepted word
         ip_len_in  = ip_len_ff;
         tcp_len_in = tcp_len_ff;
      end
   end

   // One hash multiply step per cycle while mul_en is set
   always_comb begin
      case (cmd.mul_sel)
         scc_pkg::MUL_SEL_SA: begin
            mul_src = scc_pkg::FNV_BASIS ^ secret_ff;
            mul_key = scc_pkg::swap32(sa_ff);
         end
         scc_pkg::MUL_SEL_DA: begin
            mul_src = hash_ff;
            mul_key = scc_pkg::swap32(da_ff);
         end
         scc_pkg::MUL_SEL_PORTS: begin
            mul_src = hash_ff;
            mul_key = {scc_pkg::swap16(sp_ff), scc_pkg::swap16(dp_ff)};
         end
         default: begin
            mul_src = hash_ff;
            mul_key = '0;
         end
      endcase
      mul_op  = mul_src ^ mul_key;
      hash_in = cmd.mul_en ? (mul_op * scc_pkg::FNV_PRIME) : hash_ff;
   end

   // Final mix, TCP checksum with pseudo-header and cookie, header check
   always_comb begin
      h_final = hash_ff ^ (hash_ff >> 13);
      // cookie halves, counted twice (seq and ack)
      ck_sum = TW'(h_final[31:16]) + TW'(h_final[15:0]);
      tsum = TW'(tcp_sum_ff)
           + TW'(sa_ff[31:16]) + TW'(sa_ff[15:0])
           + TW'(da_ff[31:16]) + TW'(da_ff[15:0])
           + TW'(scc_pkg::PROTO_TCP) + TW'({tcp_len_ff, 2'b00})
           + {ck_sum[TW-2:0], 1'b0};
      len_total = 7'({ip_len_ff, 1'b0}) + 7'({tcp_len_ff, 1'b0});
      err_now = (ip_len_ff < scc_pkg::MIN_HDR_LEN) || (tcp_len_ff < scc_pkg::MIN_HDR_LEN)
             || (7'(pos_ff) != len_total);
   end

   // Packet state: updated per word, cleared on reset and when the result is loaded
   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         pos_ff     <= '0;
         ip_len_ff  <= '0;
         tcp_len_ff <= '0;
         ip_sum_ff  <= '0;
         tcp_sum_ff <= '0;
         sa_ff      <= '0;
         da_ff      <= '0;
         sp_ff      <= '0;
         dp_ff      <= '0;
         seq_ff     <= '0;
      end else begin
         pos_ff     <= pos_in;
         ip_len_ff  <= ip_len_in;
         tcp_len_ff <= tcp_len_in;
         ip_sum_ff  <= ip_sum_in;
         tcp_sum_ff <= tcp_sum_in;
         sa_ff      <= sa_in;
         da_ff      <= da_in;
         sp_ff      <= sp_in;
         dp_ff      <= dp_in;
         seq_ff     <= seq_in;
      end
   end

   // Secret register
   always_ff @(posedge clock) begin
      if (reset) begin
         secret_ff <= '0;
      end else if (csr_write_enable) begin
         secret_ff <= csr_write_data;
      end
   end

   // Hash accumulator
   always_ff @(posedge clock) begin
      hash_ff <= hash_in;
   end

   // Result word register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         cookie_ff   <= h_final;
         ip_csum_ff  <= scc_pkg::fold_invert(TW'(ip_sum_ff));
         tcp_csum_ff <= scc_pkg::fold_invert(tsum);
         match_ff    <= (seq_ff == h_final);
         err_ff      <= err_now;
      end
   end

   assign cookie       = cookie_ff;
   assign ip_checksum  = ip_csum_ff;
   assign tcp_checksum = tcp_csum_ff;
   assign seq_matches  = match_ff;
   assign header_error = err_ff;

endmodule

// File: rtl/core/scc_ctrl.sv
// ----------------------------------------------------------------------------
// scc_ctrl
// Sequencer: takes header words, runs the three hash steps, then loads the
// result word once the output register is free.
// ----------------------------------------------------------------------------
module scc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_last,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output scc_pkg::scc_cmd_type  cmd
);

   localparam logic [2:0] S_RX        = 3'd0;
   localparam logic [2:0] S_MUL_SA    = 3'd1;
   localparam logic [2:0] S_MUL_DA    = 3'd2;
   localparam logic [2:0] S_MUL_PORTS = 3'd3;
   localparam logic [2:0] S_FIN       = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.mul_sel = scc_pkg::MUL_SEL_SA;
      out_free    = !rsp_valid_ff || rsp_ready;
      case (state_ff)
         S_RX: begin
            cmd.accept = req_valid;
            if (req_valid && req_last) begin
               state_in = S_MUL_SA;
            end
         end
         S_MUL_SA: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = scc_pkg::MUL_SEL_SA;
            state_in    = S_MUL_DA;
         end
         S_MUL_DA: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = scc_pkg::MUL_SEL_DA;
            state_in    = S_MUL_PORTS;
         end
         S_MUL_PORTS: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = scc_pkg::MUL_SEL_PORTS;
            state_in    = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_RX;
            end
         end
         default: state_in = S_RX;
      endcase

      // Output valid: set on load, dropped once taken
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_RX;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_RX);
   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   // A last word always starts the hash sequence
   a_last_starts_hash: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> state_ff == S_MUL_SA)
      else $error("last word did not start hash steps");

   // Result only loaded into a free output register
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a pending word");

   // Words are never taken while the hash runs
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_en |-> !req_ready)
      else $error("word accepted during hash steps");

   // Result appears the cycle after a load
   a_valid_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid)
      else $error("result not shown after load");
`endif

endmodule
